>>> rtl/esds_pkg.sv
`timescale 1ns / 1ps

package esds_pkg;

    localparam int SLOTS_DEF = 8;
    localparam logic [31:0] IDLE_RELOAD_DEF = 32'd200000000;

    localparam int OP_W      = 2;
    localparam int SLOT_W    = 3;
    localparam int CYC_W     = 29;
    localparam int JIT_W     = 32;
    localparam int TIME_W    = 32;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 136;
    localparam int M_TUSER_W = 1;

    localparam logic [TIME_W-1:0] ALL_ONES = '1;

    typedef enum logic [OP_W-1:0] {
        OP_REQUEST = 2'd0,
        OP_TICK    = 2'd1,
        OP_QUERY   = 2'd2,
        OP_REARM   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_WRITE,
        ST_READ,
        ST_LATCH,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_FIN,
        ST_EMIT_RD,
        ST_EMIT_OUT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] end_time;
    } slot_ent_t;

endpackage

>>> rtl/esds_slot_ram.sv
`timescale 1ns / 1ps

module esds_slot_ram #(
    parameter int SLOTS  = esds_pkg::SLOTS_DEF,
    parameter int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  esds_pkg::slot_ent_t wr_data,
    input  logic               rd_en,
    input  logic [ADDR_W-1:0]  rd_addr,
    output esds_pkg::slot_ent_t rd_data
);
    import esds_pkg::*;

    slot_ent_t             mem_reg [SLOTS];
    slot_ent_t             rd_data_reg;
    logic [SLOTS-1:0]      vld_reg;
    logic                  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    // entries never written read back as disarmed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : slot_ent_t'({ALL_ONES, ALL_ONES});

endmodule

>>> rtl/event_slot_deadline_scheduler_core.sv
`timescale 1ns / 1ps
// channel   dir   tdata (low bit up)                              tuser        tlast
// s_*       in    slot, cycles, jitter_in                         operation    -
// m_*       out   fired_slot, remain, jitter, remaining,          fired        last
//                 now_time, zero pad
//
// query reads its slot and answers; request and rearm that arm or disarm a slot
// write it, then rescan every slot for the nearest deadline before they answer
// tick returns to idle unless the countdown runs out; then it rescans every slot
// and walks the slot ram, reading back and reporting each fired slot in turn
// one request in flight; s_tready is high only while idle
// a full output register holds the sequencer, and with it the input side
// reset clears per-entry valid bits, so no clearing pass is needed

module event_slot_deadline_scheduler_core #(
    parameter int          SLOTS       = esds_pkg::SLOTS_DEF,
    parameter logic [31:0] IDLE_RELOAD = esds_pkg::IDLE_RELOAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [esds_pkg::S_TDATA_W-1:0] s_tdata,  // slot, cycles, jitter_in
    input  logic [esds_pkg::OP_W-1:0]      s_tuser,  // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [esds_pkg::M_TDATA_W-1:0] m_tdata,  // fired_slot, remain, jitter, remaining, now_time
    output logic [esds_pkg::M_TUSER_W-1:0] m_tuser,  // fired
    output logic                          m_tlast
);
    import esds_pkg::*;

    localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(SLOTS - 1);

    state_t state_reg, state_next;

    op_t                      op_reg, op_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [CYC_W-1:0]         cyc_reg, cyc_next;
    logic [JIT_W-1:0]         jin_reg, jin_next;
    logic [TIME_W-1:0]        t_reg, t_next;
    logic [TIME_W-1:0]        fz_reg, fz_next;
    logic [TIME_W-1:0]        c_reg, c_next;
    logic [TIME_W-1:0]        end_reg, end_next;
    logic [TIME_W-2:0]        dly_reg, dly_next;
    logic                     neg_reg, neg_next;
    logic [TIME_W-1:0]        best_reg, best_next;
    logic                     found_reg, found_next;
    logic [TIME_W-1:0]        base_reg, base_next;
    logic [TIME_W-1:0]        cd_reg, cd_next;
    logic                     ev_reg, ev_next;
    logic                     fire_en_reg, fire_en_next;
    logic [SLOTS-1:0]         mask_reg, mask_next;
    logic [ADDR_W-1:0]        cnt_reg, cnt_next;
    logic                     pipe_reg, pipe_next;
    logic [ADDR_W-1:0]        pipe_idx_reg, pipe_idx_next;

    logic                     out_vld_reg, out_vld_next;
    logic                     out_fired_reg, out_fired_next;
    logic [SLOT_W-1:0]        out_slot_reg, out_slot_next;
    logic [TIME_W-1:0]        out_rem_reg, out_rem_next;
    logic [TIME_W-1:0]        out_jit_reg, out_jit_next;
    logic [TIME_W-1:0]        out_left_reg, out_left_next;
    logic [TIME_W-1:0]        out_now_reg, out_now_next;
    logic                     out_last_reg, out_last_next;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    slot_ent_t                wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    slot_ent_t                rd_data;

    logic [TIME_W-1:0]        c_in;
    logic [TIME_W-1:0]        cd_sub;
    logic                     slot_ok;
    logic [ADDR_W-1:0]        slot_idx;
    logic [33:0]              rearm_diff;
    logic [TIME_W-2:0]        rearm_dly;
    logic                     rearm_go;
    logic [TIME_W-1:0]        end_sum;
    logic [TIME_W-1:0]        end_calc;
    logic                     ent_armed;
    logic                     fire_hit;
    logic [TIME_W-1:0]        ent_left;
    logic [TIME_W-1:0]        cd_new;
    logic                     last_hit;
    logic                     out_free;
    logic                     out_load;

    esds_slot_ram #(
        .SLOTS  (SLOTS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign c_in     = cyc_reg[CYC_W-1] ? '0 : {{(TIME_W-CYC_W){1'b0}}, cyc_reg};
    assign cd_sub   = cd_reg - c_in;
    assign slot_ok  = {{(32-SLOT_W){1'b0}}, slot_reg} < 32'(SLOTS);
    assign slot_idx = ADDR_W'(slot_reg);

    // rearm delay is cycles minus jitter, clamped to 0 .. 2^31-1
    assign rearm_diff = {{(34-CYC_W){cyc_reg[CYC_W-1]}}, cyc_reg}
                      - {{(34-JIT_W){jin_reg[JIT_W-1]}}, jin_reg};
    assign rearm_go   = !cyc_reg[CYC_W-1] && (cyc_reg != '0);
    always_comb
    begin
        if (rearm_diff[33])
        begin
            rearm_dly = '0;
        end
        else if (rearm_diff[32:31] != 2'b00)
        begin
            rearm_dly = '1;
        end
        else
        begin
            rearm_dly = rearm_diff[30:0];
        end
    end

    assign end_sum  = t_reg + {1'b0, dly_reg};
    assign end_calc = neg_reg ? ALL_ONES : ((end_sum == ALL_ONES) ? '0 : end_sum);

    assign ent_armed = rd_data.end_time != ALL_ONES;
    assign fire_hit  = fire_en_reg && ent_armed && ((rd_data.end_time - fz_reg) <= c_reg);
    assign ent_left  = ent_armed ? (rd_data.end_time - t_reg) : ALL_ONES;

    assign cd_new   = found_reg ? best_reg : IDLE_RELOAD;
    assign last_hit = (mask_reg & ~(SLOTS'(1) << cnt_reg)) == '0;
    assign out_free = !out_vld_reg || m_tready;

    assign s_tready = state_reg == ST_IDLE;

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        cyc_next      = cyc_reg;
        jin_next      = jin_reg;
        t_next        = t_reg;
        fz_next       = fz_reg;
        c_next        = c_reg;
        end_next      = end_reg;
        dly_next      = dly_reg;
        neg_next      = neg_reg;
        best_next     = best_reg;
        found_next    = found_reg;
        base_next     = base_reg;
        cd_next       = cd_reg;
        ev_next       = ev_reg;
        fire_en_next  = fire_en_reg;
        mask_next     = mask_reg;
        cnt_next      = cnt_reg;
        pipe_next     = 1'b0;
        pipe_idx_next = pipe_idx_reg;

        out_load       = 1'b0;
        out_fired_next = out_fired_reg;
        out_slot_next  = out_slot_reg;
        out_rem_next   = out_rem_reg;
        out_jit_next   = out_jit_reg;
        out_left_next  = out_left_reg;
        out_now_next   = out_now_reg;
        out_last_next  = out_last_reg;

        wr_en   = 1'b0;
        wr_addr = slot_idx;
        wr_data = slot_ent_t'({t_reg, end_calc});
        rd_en   = 1'b0;
        rd_addr = cnt_reg;

        // scan result: firing slots are marked, the rest compete for nearest deadline
        if (pipe_reg)
        begin
            if (fire_hit)
            begin
                mask_next[pipe_idx_reg] = 1'b1;
            end
            else if (ent_left < best_reg)
            begin
                best_next  = ent_left;
                found_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = op_t'(s_tuser);
                    slot_next  = s_tdata[SLOT_W-1:0];
                    cyc_next   = s_tdata[SLOT_W+CYC_W-1:SLOT_W];
                    jin_next   = s_tdata[SLOT_W+CYC_W+JIT_W-1:SLOT_W+CYC_W];
                    t_next     = base_reg - cd_reg;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cnt_next   = '0;
                best_next  = ALL_ONES;
                found_next = 1'b0;
                mask_next  = '0;
                unique case (op_reg)
                    OP_TICK:
                    begin
                        cd_next = cd_sub;
                        c_next  = c_in;
                        fz_next = t_reg;
                        t_next  = t_reg + c_in;
                        if (cd_sub[TIME_W-1])
                        begin
                            fire_en_next = ev_reg;
                            state_next   = ST_SCAN;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    OP_REQUEST:
                    begin
                        neg_next   = cyc_reg[CYC_W-1];
                        dly_next   = {{(TIME_W-1-CYC_W){1'b0}}, cyc_reg};
                        state_next = slot_ok ? ST_WRITE : ST_READ;
                    end
                    OP_REARM:
                    begin
                        neg_next   = 1'b0;
                        dly_next   = rearm_dly;
                        state_next = (slot_ok && rearm_go) ? ST_WRITE : ST_READ;
                    end
                    OP_QUERY:
                    begin
                        state_next = ST_READ;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_WRITE:
            begin
                wr_en        = 1'b1;
                end_next     = end_calc;
                fire_en_next = 1'b0;
                state_next   = ST_SCAN;
            end
            ST_SCAN:
            begin
                rd_en         = 1'b1;
                rd_addr       = cnt_reg;
                pipe_next     = 1'b1;
                pipe_idx_next = cnt_reg;
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_SCAN_LAST;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN_LAST:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cd_next   = cd_new;
                base_next = t_reg + cd_new;
                ev_next   = found_reg;
                cnt_next  = '0;
                if (op_reg == OP_TICK)
                begin
                    state_next = (mask_reg != '0) ? ST_EMIT_RD : ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_READ:
            begin
                rd_en      = slot_ok;
                rd_addr    = slot_idx;
                state_next = ST_LATCH;
            end
            ST_LATCH:
            begin
                end_next   = slot_ok ? rd_data.end_time : ALL_ONES;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_fired_next = 1'b0;
                    out_slot_next  = slot_reg;
                    out_rem_next   = '0;
                    out_jit_next   = '0;
                    out_left_next  = (end_reg == ALL_ONES) ? ALL_ONES : (end_reg - t_reg);
                    out_now_next   = t_reg;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT_RD:
            begin
                if (mask_reg[cnt_reg])
                begin
                    rd_en      = 1'b1;
                    rd_addr    = cnt_reg;
                    state_next = ST_EMIT_OUT;
                end
                else if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT_OUT:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    out_fired_next = 1'b1;
                    out_slot_next  = SLOT_W'(cnt_reg);
                    out_rem_next   = rd_data.end_time - rd_data.start_time;
                    out_jit_next   = t_reg - rd_data.end_time;
                    out_left_next  = ALL_ONES;
                    out_now_next   = t_reg;
                    out_last_next  = last_hit;
                    wr_en          = 1'b1;
                    wr_addr        = cnt_reg;
                    wr_data        = slot_ent_t'({t_reg, ALL_ONES});
                    mask_next[cnt_reg] = 1'b0;
                    if (last_hit || (cnt_reg == LAST_IDX))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            base_reg    <= '0;
            cd_reg      <= '0;
            ev_reg      <= 1'b0;
            fire_en_reg <= 1'b0;
            mask_reg    <= '0;
            cnt_reg     <= '0;
            pipe_reg    <= 1'b0;
            found_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            cd_reg      <= cd_next;
            ev_reg      <= ev_next;
            fire_en_reg <= fire_en_next;
            mask_reg    <= mask_next;
            cnt_reg     <= cnt_next;
            pipe_reg    <= pipe_next;
            found_reg   <= found_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        slot_reg      <= slot_next;
        cyc_reg       <= cyc_next;
        jin_reg       <= jin_next;
        t_reg         <= t_next;
        fz_reg        <= fz_next;
        c_reg         <= c_next;
        end_reg       <= end_next;
        dly_reg       <= dly_next;
        neg_reg       <= neg_next;
        best_reg      <= best_next;
        pipe_idx_reg  <= pipe_idx_next;
        out_fired_reg <= out_fired_next;
        out_slot_reg  <= out_slot_next;
        out_rem_reg   <= out_rem_next;
        out_jit_reg   <= out_jit_next;
        out_left_reg  <= out_left_next;
        out_now_reg   <= out_now_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_now_reg, out_left_reg, out_jit_reg, out_rem_reg, out_slot_reg};
    assign m_tuser  = out_fired_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> rtl/esds_checker.sv
`timescale 1ns / 1ps

module esds_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [esds_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [esds_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tlast
);
    import esds_pkg::*;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a request is in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // non-fire answers are single results with zero remain and jitter
    a_answer_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata[66:3] == '0))
        else $error("malformed answer result");

    // a fired slot is disarmed by the time it is reported
    a_fired_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[98:67] == ALL_ONES)
        else $error("fired slot not reported as disarmed");

endmodule

bind event_slot_deadline_scheduler_core esds_checker u_esds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/tb_event_slot_deadline_scheduler_core.sv
`timescale 1ns / 1ps

module tb_event_slot_deadline_scheduler_core;

    import esds_pkg::*;

    localparam int          NUM_SLOTS   = SLOTS_DEF;
    localparam int          CYCLE_LIMIT = 300000;
    localparam int          HOLD_CYCLES = 300;
    localparam logic [28:0] CYC_DISARM  = '1;
    localparam logic [28:0] CYC_MIN     = 29'h1000_0000;
    localparam logic [28:0] CYC_MAX     = 29'h0FFF_FFFF;

    typedef struct packed {
        logic        fired;
        logic [2:0]  slot;
        logic [31:0] remain;
        logic [31:0] jitter;
        logic [31:0] remaining;
        logic [31:0] now_t;
        logic        is_last;
    } timer_result_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [OP_W-1:0]        s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    int tx_idle_pct = 24;
    int rx_idle_pct = 24;
    logic hold_start = 1'b0;
    logic hold_done  = 1'b0;
    int mismatch_cnt = 0;
    int cycle_cnt = 0;

    timer_result_t timer_results_due[$];

    // predictor state
    logic [31:0] due_start[NUM_SLOTS];
    logic [31:0] due_end[NUM_SLOTS];
    logic [63:0] epoch;
    logic [31:0] down_cnt;
    logic        pending_valid;

    event_slot_deadline_scheduler_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [63:0] sext_count(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic [31:0] now_lo();
        logic [63:0] t;
        t = epoch - sext_count(down_cnt);
        return t[31:0];
    endfunction

    function automatic logic [31:0] left_of(input int i, input logic [31:0] t);
        if (due_end[i] != ALL_ONES)
            return due_end[i] - t;
        return ALL_ONES;
    endfunction

    function automatic void queue_result(input timer_result_t r);
        timer_results_due = {timer_results_due, r};
    endfunction

    task automatic clear_timer_state();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            due_start[i] = ALL_ONES;
            due_end[i]   = ALL_ONES;
        end
        epoch         = '0;
        down_cnt      = '0;
        pending_valid = 1'b0;
    endtask

    // nearest deadline, or the idle reload if none is armed, reloads the countdown
    task automatic rescan_deadline();
        logic [31:0] t;
        logic [31:0] best;
        logic [31:0] r;
        logic        found;
        t     = now_lo();
        best  = ALL_ONES;
        found = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            r = left_of(i, t);
            if (r < best)
            begin
                best  = r;
                found = 1'b1;
            end
        end
        epoch         = epoch - sext_count(down_cnt);
        down_cnt      = found ? best : IDLE_RELOAD_DEF;
        epoch         = epoch + sext_count(down_cnt);
        pending_valid = found;
    endtask

    task automatic set_deadline(input int s, input longint delay);
        logic [63:0] d;
        d            = delay;
        due_start[s] = now_lo();
        if (delay < 0)
            due_end[s] = ALL_ONES;
        else
        begin
            due_end[s] = due_start[s] + d[31:0];
            if (due_end[s] == ALL_ONES)
                due_end[s] = '0;
        end
        rescan_deadline();
    endtask

    task automatic predict_timer_item(input op_t op, input logic [2:0] s,
                                      input logic [28:0] cyc_raw,
                                      input logic [31:0] jit_raw);
        longint        cyc;
        longint        jin;
        longint        d;
        logic [31:0]   c;
        logic [31:0]   t;
        logic [31:0]   fz;
        logic [31:0]   rem;
        logic [31:0]   el;
        int            n;
        timer_result_t batch[NUM_SLOTS];
        timer_result_t res;
        cyc = $signed(cyc_raw);
        jin = $signed(jit_raw);
        n   = 0;
        if (op == OP_TICK)
        begin
            c        = (cyc < 0) ? 32'd0 : 32'(cyc);
            down_cnt = down_cnt - c;
            if (down_cnt[31])
            begin
                t  = now_lo();
                fz = t - c;
                if (pending_valid)
                begin
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (due_end[i] != ALL_ONES && (due_end[i] - fz) <= c)
                        begin
                            rem          = due_end[i] - due_start[i];
                            el           = t - due_start[i];
                            due_start[i] = t;
                            due_end[i]   = ALL_ONES;
                            batch[n]     = {1'b1, 3'(i), rem, el - rem, ALL_ONES, t, 1'b0};
                            n++;
                        end
                    end
                end
                rescan_deadline();
            end
            for (int k = 0; k < n; k++)
            begin
                res         = batch[k];
                res.is_last = (k == n - 1);
                queue_result(res);
            end
        end
        else
        begin
            if (op == OP_REQUEST)
                set_deadline(s, cyc);
            else if (op == OP_REARM && cyc > 0)
            begin
                d = cyc - jin;
                if (d < 0)
                    d = 0;
                if (d > 64'sh7FFF_FFFF)
                    d = 64'sh7FFF_FFFF;
                set_deadline(s, d);
            end
            res = {1'b0, s, 32'd0, 32'd0, left_of(s, now_lo()), now_lo(), 1'b1};
            queue_result(res);
        end
    endtask

    task automatic send_timer_request(input op_t op, input logic [2:0] s,
                                      input logic [28:0] cyc, input logic [31:0] jit);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {jit, cyc, s};
        do
            @(posedge clk);
        while (!s_tready);
        predict_timer_item(op, s, cyc, jit);
    endtask

    task automatic halt_sender();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_results();
        halt_sender();
        while (timer_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_request();
        int          pick;
        op_t         op;
        logic [28:0] cyc;
        logic [31:0] jit;
        pick = $urandom_range(99);
        if (pick < 35)
            op = OP_REQUEST;
        else if (pick < 70)
            op = OP_TICK;
        else if (pick < 85)
            op = OP_QUERY;
        else
            op = OP_REARM;
        pick = $urandom_range(99);
        if (op == OP_TICK)
        begin
            if (pick < 70)
                cyc = 29'($urandom_range(120));
            else if (pick < 80)
                cyc = '0;
            else if (pick < 92)
                cyc = 29'($urandom);
            else
                cyc = 29'($urandom_range(200000000));
        end
        else
        begin
            if (pick < 78)
                cyc = 29'($urandom_range(300));
            else if (pick < 86)
                cyc = CYC_DISARM;
            else if (pick < 94)
                cyc = 29'($urandom);
            else
                cyc = 29'($urandom_range(200000000));
        end
        if ($urandom_range(99) < 70)
            jit = 32'($urandom_range(40)) - 32'd20;
        else
            jit = $urandom;
        send_timer_request(op, 3'($urandom_range(NUM_SLOTS - 1)), cyc, jit);
    endtask

    task automatic test_idle_query();
        send_timer_request(OP_QUERY, 3'd0, '0, '0);
        send_timer_request(OP_QUERY, 3'd7, '0, '0);
    endtask

    task automatic test_arm_and_fire();
        send_timer_request(OP_REQUEST, 3'd1, 29'd5, '0);
        send_timer_request(OP_REQUEST, 3'd2, 29'd5, '0);
        send_timer_request(OP_REQUEST, 3'd7, 29'd0, '0);
        send_timer_request(OP_REQUEST, 3'd3, CYC_MAX, '0);
        send_timer_request(OP_REQUEST, 3'd4, CYC_DISARM, '0);
        send_timer_request(OP_REQUEST, 3'd5, CYC_MIN, '0);
        // negative tick count counts as zero
        send_timer_request(OP_TICK, 3'd0, CYC_MIN, '0);
        send_timer_request(OP_TICK, 3'd0, 29'd1, '0);
        // two slots due at the same time
        send_timer_request(OP_TICK, 3'd0, 29'd10, '0);
        send_timer_request(OP_QUERY, 3'd3, '0, '0);
    endtask

    task automatic test_rearm();
        send_timer_request(OP_REARM, 3'd1, 29'd0, '0);
        send_timer_request(OP_REARM, 3'd1, CYC_DISARM, '0);
        send_timer_request(OP_REARM, 3'd1, 29'd10, 32'd4);
        send_timer_request(OP_REARM, 3'd2, 29'd5, 32'h7FFF_FFFF);
        send_timer_request(OP_REARM, 3'd6, CYC_MAX, 32'h8000_0000);
        send_timer_request(OP_TICK, 3'd0, CYC_MAX, 32'hFFFF_FFFF);
        send_timer_request(OP_QUERY, 3'd6, '0, '0);
    endtask

    task automatic test_disarm();
        send_timer_request(OP_REQUEST, 3'd6, CYC_DISARM, '0);
        send_timer_request(OP_QUERY, 3'd6, '0, '0);
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_backpressure();
        hold_start <= 1'b1;
        repeat (12)
            send_random_request();
    endtask

    task automatic test_random(input int count);
        repeat (count)
            send_random_request();
    endtask

    task automatic test_no_idle(input int count);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random(count);
        tx_idle_pct = 24;
        rx_idle_pct = 24;
    endtask

    always @(negedge clk)
    begin
        if (hold_start && !hold_done)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    initial
    begin
        wait (hold_start);
        repeat (HOLD_CYCLES)
            @(negedge clk);
        hold_done <= 1'b1;
    end

    task automatic flag_mismatch(input string what, input timer_result_t exp_r,
                                 input timer_result_t got_r);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
        begin
            $display("%s: expected fired=%0b slot=%0d remain=%h jitter=%h",
                     what, exp_r.fired, exp_r.slot, exp_r.remain, exp_r.jitter);
            $display("    remaining=%h now=%h last=%0b",
                     exp_r.remaining, exp_r.now_t, exp_r.is_last);
            $display("  got fired=%0b slot=%0d remain=%h jitter=%h",
                     got_r.fired, got_r.slot, got_r.remain, got_r.jitter);
            $display("    remaining=%h now=%h last=%0b",
                     got_r.remaining, got_r.now_t, got_r.is_last);
        end
    endtask

    always @(posedge clk)
    begin
        timer_result_t got_r;
        timer_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_r = {m_tuser[0], m_tdata[2:0], m_tdata[34:3], m_tdata[66:35],
                     m_tdata[98:67], m_tdata[130:99], m_tlast};
            if (timer_results_due.size() == 0)
                flag_mismatch("unexpected result", '0, got_r);
            else
            begin
                exp_r = timer_results_due.pop_front();
                if (got_r !== exp_r)
                    flag_mismatch("result mismatch", exp_r, got_r);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("event_slot_deadline_scheduler_core test failed");
            $finish;
        end
    end

    initial
    begin
        clear_timer_state();
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_query();
        test_arm_and_fire();
        test_rearm();
        test_disarm();
        wait_for_results();
        test_backpressure();
        test_random(140);
        wait_for_results();
        test_no_idle(60);
        test_random(140);
        wait_for_results();
        repeat (50)
            @(posedge clk);
        if (mismatch_cnt == 0 && timer_results_due.size() == 0)
            $display("event_slot_deadline_scheduler_core test passed");
        else
            $display("event_slot_deadline_scheduler_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/esds_pkg.sv
rtl/esds_slot_ram.sv
rtl/event_slot_deadline_scheduler_core.sv
rtl/esds_checker.sv
bench/tb_event_slot_deadline_scheduler_core.sv
